[rtl/drbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbp_pkg: shared types and constants of the delta record bit packer
// Holds the command codes, the queue entry layout and the zigzag and
// significant-width helpers used by the front end.
// ----------------------------------------------------------------------------
package drbp_pkg;

   // Stream layout.
   localparam int WORD_BITS  = 32;
   localparam int HDR_BITS   = 6;
   localparam int ZZ_BITS    = 33;
   localparam int FIELDS     = 4;
   localparam int SEG_BITS   = ZZ_BITS + HDR_BITS;
   localparam int ACC_BITS   = SEG_BITS + 7;
   localparam int CNT_BITS   = 6;
   localparam int TOTAL_BITS = 8;
   localparam int BYTES_BITS = 5;
   localparam int SEG_IDX_BITS = 3;

   // Fixed part of a record: id plus four width headers.
   localparam int RECORD_FIXED_BITS = WORD_BITS + FIELDS * HDR_BITS;

   // Queue between front and back.
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_WORD   = 2'd0,
      CMD_RECORD = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef logic [ZZ_BITS-1:0]  zz_type;
   typedef logic [HDR_BITS-1:0] hdr_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic [WORD_BITS-1:0]      word;
      zz_type [FIELDS-1:0]       zz;
      hdr_type [FIELDS-1:0]      wid;
      logic [TOTAL_BITS-1:0]     total;
   } entry_type;

   // Zigzag code of cur - base, taken at 33 bits so it never overflows.
   function automatic zz_type zigzag(input logic [WORD_BITS-1:0] cur,
                                     input logic [WORD_BITS-1:0] base);
      logic [ZZ_BITS-1:0] d;
      logic [ZZ_BITS:0]   z;
      d = {cur[WORD_BITS-1], cur} - {base[WORD_BITS-1], base};
      z = {d, 1'b0} ^ {(ZZ_BITS + 1){d[ZZ_BITS-1]}};
      return z[ZZ_BITS-1:0];
   endfunction

   // Number of significant bits: position of the highest one plus one.
   function automatic hdr_type sig_width(input zz_type v);
      hdr_type w;
      w = '0;
      for (int i = 0; i < ZZ_BITS; i++) begin
         if (v[i]) begin
            w = hdr_type'(i + 1);
         end
      end
      return w;
   endfunction

endpackage

[rtl/drbp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbp_front: request intake and classification
// Takes a request word, drops unused commands, forms the four zigzag deltas
// with their widths and the total bit length, and pushes one queue entry.
// ----------------------------------------------------------------------------
module drbp_front (
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_word,
   input  logic [31:0] req_cur_x,
   input  logic [31:0] req_cur_y,
   input  logic [31:0] req_cur_z,
   input  logic [31:0] req_cur_yaw,
   input  logic [31:0] req_base_x,
   input  logic [31:0] req_base_y,
   input  logic [31:0] req_base_z,
   input  logic [31:0] req_base_yaw,
   input  logic        req_base_valid,
   input  logic        q_full,
   output logic        q_push,
   output drbp_pkg::entry_type q_entry
);

   logic [31:0] cur [drbp_pkg::FIELDS];
   logic [31:0] base [drbp_pkg::FIELDS];
   logic        cmd_known;
   logic [drbp_pkg::TOTAL_BITS-1:0] wid_sum;

   assign cur[0] = req_cur_x;
   assign cur[1] = req_cur_y;
   assign cur[2] = req_cur_z;
   assign cur[3] = req_cur_yaw;

   // Baselines read as zero for a new entity.
   assign base[0] = req_base_valid ? req_base_x   : '0;
   assign base[1] = req_base_valid ? req_base_y   : '0;
   assign base[2] = req_base_valid ? req_base_z   : '0;
   assign base[3] = req_base_valid ? req_base_yaw : '0;

   // Decode the command; the unused code is accepted and dropped.
   always_comb begin
      unique case (drbp_pkg::cmd_type'(req_cmd))
         drbp_pkg::CMD_WORD,
         drbp_pkg::CMD_RECORD,
         drbp_pkg::CMD_FLUSH: cmd_known = 1'b1;
         default:             cmd_known = 1'b0;
      endcase
   end

   // Queue entry: field deltas and their significant widths, one lane per
   // field, plus the total bit length of the item.
   always_comb begin
      q_entry.cmd  = drbp_pkg::cmd_type'(req_cmd);
      q_entry.word = req_word;
      wid_sum = drbp_pkg::TOTAL_BITS'(drbp_pkg::RECORD_FIXED_BITS);
      for (int k = 0; k < drbp_pkg::FIELDS; k++) begin
         q_entry.zz[k]  = drbp_pkg::zigzag(cur[k], base[k]);
         q_entry.wid[k] = drbp_pkg::sig_width(q_entry.zz[k]);
         wid_sum = wid_sum + drbp_pkg::TOTAL_BITS'(q_entry.wid[k]);
      end
      q_entry.total = (drbp_pkg::cmd_type'(req_cmd) == drbp_pkg::CMD_RECORD)
                      ? wid_sum
                      : drbp_pkg::TOTAL_BITS'(drbp_pkg::WORD_BITS);
   end

   // Handshake: the queue alone holds the requester back.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && cmd_known;

endmodule

[rtl/drbp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbp_queue: short entry queue between front and back
// A small register queue that lets the front take new words while the back
// is still packing earlier ones.
// ----------------------------------------------------------------------------
module drbp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  drbp_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output drbp_pkg::entry_type head_entry
);

   drbp_pkg::entry_type slot_ff [drbp_pkg::Q_DEPTH];
   logic [drbp_pkg::Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [drbp_pkg::Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [drbp_pkg::Q_CNT_BITS-1:0] cnt_ff, cnt_in;

   function automatic logic [drbp_pkg::Q_PTR_BITS-1:0] ptr_next(
         input logic [drbp_pkg::Q_PTR_BITS-1:0] p);
      if (p == drbp_pkg::Q_PTR_BITS'(drbp_pkg::Q_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full       = (cnt_ff == drbp_pkg::Q_CNT_BITS'(drbp_pkg::Q_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/drbp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbp_back: bit accumulator and byte emitter
// Walks the head entry's segments (id, then header plus payload per field),
// appends each to an accumulator and drains one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module drbp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  drbp_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run
);

   logic [drbp_pkg::ACC_BITS-1:0]     acc_ff, acc_in;
   logic [drbp_pkg::CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [drbp_pkg::SEG_IDX_BITS-1:0] seg_ff, seg_in;
   logic [drbp_pkg::BYTES_BITS-1:0]   rem_ff, rem_in;
   logic                              out_valid_ff, out_valid_in;
   logic [7:0]                        out_byte_ff, out_byte_in;
   logic                              out_last_ff, out_last_in;

   logic                              slot_free;
   logic                              emit;
   logic                              load;
   logic [drbp_pkg::CNT_BITS-1:0]     eff;
   logic [drbp_pkg::ACC_BITS-1:0]     shifted;
   logic [drbp_pkg::SEG_BITS-1:0]     seg_val;
   logic [drbp_pkg::CNT_BITS-1:0]     seg_len;
   logic                              seg_final;
   logic [drbp_pkg::TOTAL_BITS-1:0]   item_bits;
   logic [drbp_pkg::TOTAL_BITS-1:0]   bit_sum;
   logic [1:0]                        fld;
   logic [2:0]                        pad;

   // Drain side: a byte leaves whenever eight bits are ready and the
   // output register is free.
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign emit      = slot_free && (cnt_ff >= drbp_pkg::CNT_BITS'(8));
   assign eff       = emit ? cnt_ff - drbp_pkg::CNT_BITS'(8) : cnt_ff;
   assign shifted   = emit ? {8'd0, acc_ff[drbp_pkg::ACC_BITS-1:8]} : acc_ff;

   // Fill side: append the next segment once fewer than eight bits remain.
   assign load  = q_valid && (eff < drbp_pkg::CNT_BITS'(8));
   assign q_pop = load && seg_final;

   assign fld = seg_ff[1:0] - 2'd1;
   assign pad = 3'd0 - eff[2:0];

   // Segment decoder for the head entry.
   always_comb begin
      seg_val   = '0;
      seg_len   = '0;
      seg_final = 1'b1;
      item_bits = '0;
      unique case (q_entry.cmd)
         drbp_pkg::CMD_WORD: begin
            seg_val   = drbp_pkg::SEG_BITS'(q_entry.word);
            seg_len   = drbp_pkg::CNT_BITS'(drbp_pkg::WORD_BITS);
            item_bits = q_entry.total;
         end
         drbp_pkg::CMD_RECORD: begin
            item_bits = q_entry.total;
            if (seg_ff == '0) begin
               seg_val   = drbp_pkg::SEG_BITS'(q_entry.word);
               seg_len   = drbp_pkg::CNT_BITS'(drbp_pkg::WORD_BITS);
               seg_final = 1'b0;
            end else begin
               seg_val   = {q_entry.zz[fld], q_entry.wid[fld]};
               seg_len   = drbp_pkg::CNT_BITS'(q_entry.wid[fld])
                           + drbp_pkg::CNT_BITS'(drbp_pkg::HDR_BITS);
               seg_final = (seg_ff == drbp_pkg::SEG_IDX_BITS'(drbp_pkg::FIELDS));
            end
         end
         drbp_pkg::CMD_FLUSH: begin
            // Zero padding up to the next byte boundary.
            seg_len   = drbp_pkg::CNT_BITS'(pad);
            item_bits = drbp_pkg::TOTAL_BITS'(pad);
         end
         default: begin
            seg_final = 1'b1;
         end
      endcase
   end

   // Bytes this item will produce, known when its first segment loads.
   assign bit_sum = drbp_pkg::TOTAL_BITS'(eff) + item_bits;

   // Next state of the accumulator, segment index and byte countdown.
   always_comb begin
      acc_in = shifted;
      cnt_in = eff;
      seg_in = seg_ff;
      rem_in = emit ? rem_ff - 1'b1 : rem_ff;
      if (load) begin
         acc_in = shifted | (drbp_pkg::ACC_BITS'(seg_val) << eff[2:0]);
         cnt_in = eff + seg_len;
         seg_in = seg_final ? '0 : seg_ff + 1'b1;
         if (seg_ff == '0) begin
            rem_in = bit_sum[drbp_pkg::TOTAL_BITS-1:3];
         end
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (slot_free) begin
         out_valid_in = emit;
         out_byte_in  = acc_ff[7:0];
         out_last_in  = (rem_ff == drbp_pkg::BYTES_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         seg_ff       <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         seg_ff       <= seg_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

[rtl/delta_record_bit_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_record_bit_packer: snapshot delta byte-stream packer
// Packs words, records (id plus four zigzag field deltas with 6-bit width
// headers) and flushes into a byte stream, least significant bit first.
//
//   Channel | Ports  | Direction | Carries
//   --------+--------+-----------+------------------------------------------
//   request | req_*  | in        | one command word with its operand fields
//   response| rsp_*  | out       | one packed byte, last byte of an item marked
//
// A word yields 4 bytes, a record 7 to 24, a flush 0 or 1; the back end
// emits at most one byte per cycle through the output register, and a run of
// short fields can leave gaps between bytes. The first byte of a request
// passes through the queue, the accumulator and the output register. A
// two-entry queue lets new requests in while earlier ones drain. Synchronous
// reset empties the queue and clears pending bits. A response stall holds
// the output byte, while the back end can still load segments; the request
// side stalls only when the queue is full.
// ----------------------------------------------------------------------------
module delta_record_bit_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_word,
   input  logic [31:0] req_cur_x,
   input  logic [31:0] req_cur_y,
   input  logic [31:0] req_cur_z,
   input  logic [31:0] req_cur_yaw,
   input  logic [31:0] req_base_x,
   input  logic [31:0] req_base_y,
   input  logic [31:0] req_base_z,
   input  logic [31:0] req_base_yaw,
   input  logic        req_base_valid,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run
);

   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_valid;
   drbp_pkg::entry_type push_entry;
   drbp_pkg::entry_type head_entry;

   // Front end: decode and classify.
   drbp_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_word       (req_word),
      .req_cur_x      (req_cur_x),
      .req_cur_y      (req_cur_y),
      .req_cur_z      (req_cur_z),
      .req_cur_yaw    (req_cur_yaw),
      .req_base_x     (req_base_x),
      .req_base_y     (req_base_y),
      .req_base_z     (req_base_z),
      .req_base_yaw   (req_base_yaw),
      .req_base_valid (req_base_valid),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   // Queue between the two halves.
   drbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   // Back end: bit packing and byte output.
   drbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (head_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[rtl/drbp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbp_checker: port-level checks for the delta record bit packer
// Watches the request and response ports and flags handshake or reset
// misbehavior.
// ----------------------------------------------------------------------------
module drbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // A stalled response word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // A stalled response word does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("response word changed while stalled");

   // Reset leaves nothing to send.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Reset leaves the queue empty, so requests are taken at once.
   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled right after reset");

endmodule

bind delta_record_bit_packer drbp_checker u_drbp_checker (.*);

[dv/delta_record_bit_packer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_record_bit_packer_tb: self-checking bench for the delta record packer
// Drives word, record, flush and unused commands through the request channel.
// An in-bench bit packer predicts every stream byte and its end-of-item mark.
// The checker compares each response against the oldest prediction. Random
// idle bursts on both sides and one long response hold-off exercise the
// handshakes and the internal queue.
// ----------------------------------------------------------------------------
module delta_record_bit_packer_tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int MAX_PRINTS      = 30;
   localparam int TAIL_CYCLES     = 40;
   localparam int HOLD_OFF_CYCLES = 300;

   // One request word as seen on the req_* ports; index 0..3 is x, y, z, yaw.
   typedef struct packed {
      logic [1:0]       cmd;
      logic [31:0]      word;
      logic [3:0][31:0] cur;
      logic [3:0][31:0] base;
      logic             base_valid;
   } request_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [31:0] req_word;
   logic [31:0] req_cur_x;
   logic [31:0] req_cur_y;
   logic [31:0] req_cur_z;
   logic [31:0] req_cur_yaw;
   logic [31:0] req_base_x;
   logic [31:0] req_base_y;
   logic [31:0] req_base_z;
   logic [31:0] req_base_yaw;
   logic        req_base_valid;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;

   // Packer state kept by the bench, and the bytes it still expects.
   logic [6:0]      held_bits;
   logic [2:0]      held_count;
   logic [7:0]      item_bytes[$];
   stream_byte_type expected_bytes[$];

   bit sender_idling;
   bit receiver_idling;
   int hold_left;
   int mismatches;
   int requests_sent;
   int records_sent;
   int bytes_checked;
   int input_stall_cycles;

   delta_record_bit_packer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_word        (req_word),
      .req_cur_x       (req_cur_x),
      .req_cur_y       (req_cur_y),
      .req_cur_z       (req_cur_z),
      .req_cur_yaw     (req_cur_yaw),
      .req_base_x      (req_base_x),
      .req_base_y      (req_base_y),
      .req_base_z      (req_base_z),
      .req_base_yaw    (req_base_yaw),
      .req_base_valid  (req_base_valid),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Clock with a 4 ns period.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard limit on run time in case the block hangs.
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns",
                  what, got, want, $time);
      end
   endtask

   // Appends n bits of value to the stream, least significant first.
   task automatic append_bits(input logic [32:0] value, input int n);
      for (int i = 0; i < n; i++) begin
         if (held_count == 3'd7) begin
            item_bytes.insert(item_bytes.size(), {value[i], held_bits});
            held_bits  = '0;
            held_count = '0;
         end else begin
            held_bits[held_count] = value[i];
            held_count++;
         end
      end
   endtask

   // Zigzag code of cur - base, formed at 33 bits.
   function automatic logic [32:0] zigzag_delta(input logic [31:0] cur,
                                                input logic [31:0] base);
      logic [32:0] diff;
      diff = {cur[31], cur} - {base[31], base};
      return {diff[31:0], 1'b0} ^ {33{diff[32]}};
   endfunction

   function automatic int bit_length(input logic [32:0] v);
      int len;
      len = 0;
      for (int i = 0; i < 33; i++) begin
         if (v[i]) len = i + 1;
      end
      return len;
   endfunction

   // Works out the bytes one accepted request completes and queues them.
   task automatic pack_request(input request_type r);
      logic [31:0]     base;
      logic [32:0]     zz;
      int              len;
      stream_byte_type sb;
      item_bytes.delete();
      case (r.cmd)
         drbp_pkg::CMD_WORD: begin
            append_bits({1'b0, r.word}, drbp_pkg::WORD_BITS);
         end
         drbp_pkg::CMD_RECORD: begin
            append_bits({1'b0, r.word}, drbp_pkg::WORD_BITS);
            for (int k = 0; k < drbp_pkg::FIELDS; k++) begin
               base = r.base_valid ? r.base[k] : 32'd0;
               zz   = zigzag_delta(r.cur[k], base);
               len  = bit_length(zz);
               append_bits(33'(len), drbp_pkg::HDR_BITS);
               append_bits(zz, len);
            end
         end
         drbp_pkg::CMD_FLUSH: begin
            if (held_count != 0) begin
               item_bytes.insert(item_bytes.size(), {1'b0, held_bits});
               held_bits  = '0;
               held_count = '0;
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < item_bytes.size(); i++) begin
         sb.data = item_bytes[i];
         sb.last = (i == item_bytes.size() - 1);
         expected_bytes.insert(expected_bytes.size(), sb);
      end
   endtask

   // Sends one request word, waits for it to be taken, then predicts it.
   task automatic send_request(input request_type r);
      int gap;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_cmd        = r.cmd;
      req_word       = r.word;
      req_cur_x      = r.cur[0];
      req_cur_y      = r.cur[1];
      req_cur_z      = r.cur[2];
      req_cur_yaw    = r.cur[3];
      req_base_x     = r.base[0];
      req_base_y     = r.base[1];
      req_base_z     = r.base[2];
      req_base_yaw   = r.base[3];
      req_base_valid = r.base_valid;
      req_valid      = 1'b1;
      do begin
         @(posedge clock);
         if (req_stall) input_stall_cycles++;
      end while (req_stall);
      if (r.cmd != CMD_UNUSED) requests_sent++;
      if (r.cmd == drbp_pkg::CMD_RECORD) records_sent++;
      pack_request(r);
   endtask

   function automatic request_type word_request(input logic [1:0] cmd,
                                                input logic [31:0] word);
      request_type r;
      r            = '0;
      r.cmd        = cmd;
      r.word       = word;
      r.cur        = {4{32'h5A5A_A5A5}};
      r.base       = {4{32'hA5A5_5A5A}};
      r.base_valid = 1'b1;
      return r;
   endfunction

   function automatic request_type record_request(input logic [31:0] id,
                                                  input logic [31:0] cx, input logic [31:0] cy,
                                                  input logic [31:0] cz, input logic [31:0] cw,
                                                  input logic [31:0] bx, input logic [31:0] by,
                                                  input logic [31:0] bz, input logic [31:0] bw,
                                                  input logic hb);
      request_type r;
      r.cmd        = drbp_pkg::CMD_RECORD;
      r.word       = id;
      r.cur        = {cw, cz, cy, cx};
      r.base       = {bw, bz, by, bx};
      r.base_valid = hb;
      return r;
   endfunction

   // Field value biased toward zero, powers of two and the signed extremes.
   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0:       return 32'($urandom_range(0, 64)) - 32'd32;
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         2:       return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type random_request(input logic [1:0] cmd);
      request_type r;
      int          mode;
      r.cmd        = cmd;
      r.word       = $urandom;
      r.base_valid = 1'($urandom_range(0, 1));
      for (int k = 0; k < drbp_pkg::FIELDS; k++) begin
         r.base[k] = random_value();
         mode = $urandom_range(0, 3);
         if (mode == 0) begin
            r.cur[k] = random_value();
         end else if (mode == 1) begin
            r.cur[k] = r.base[k];
         end else begin
            r.cur[k] = r.base[k] + 32'($urandom_range(0, 512)) - 32'd256;
         end
      end
      return r;
   endfunction

   function automatic logic [1:0] random_cmd();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return drbp_pkg::CMD_WORD;
      if (pick < 80) return drbp_pkg::CMD_RECORD;
      if (pick < 95) return drbp_pkg::CMD_FLUSH;
      return CMD_UNUSED;
   endfunction

   // Response side: random stall bursts, plus a long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin : drive_rsp_stall
         int stall_left;
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (stall_left != 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (receiver_idling && $urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 18);
            end
         end
      end
   end

   // Compare each accepted response byte with the oldest prediction.
   always @(posedge clock) begin : check_stream
      stream_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected byte", {24'd0, rsp_out_byte}, 32'd0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               report_mismatch("out_byte", {24'd0, rsp_out_byte}, {24'd0, want.data});
            end
            if (rsp_last_of_run !== want.last) begin
               report_mismatch("last_of_run", {31'd0, rsp_last_of_run}, {31'd0, want.last});
            end
         end
      end
   end

   // Field extremes, every command, and the zero, widest and ignored cases.
   task automatic test_directed();
      send_request(word_request(drbp_pkg::CMD_WORD, 32'h0000_0000));
      send_request(word_request(drbp_pkg::CMD_WORD, 32'hFFFF_FFFF));
      send_request(word_request(drbp_pkg::CMD_WORD, 32'hA5A5_5A5A));
      // Nothing is pending after whole words, so this flush yields no byte.
      send_request(word_request(drbp_pkg::CMD_FLUSH, 32'hFFFF_FFFF));
      // Zero deltas: four empty headers behind the id.
      send_request(record_request(32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'hFFFF_FFFF, 32'd0, 1'b1));
      // Widest deltas in both directions; two in a row give the 24-byte item.
      send_request(record_request(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
      send_request(record_request(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
      send_request(word_request(drbp_pkg::CMD_FLUSH, 32'd0));
      // No baseline: base fields are ignored and read as zero.
      send_request(record_request(32'hDEAD_BEEF, 32'h8000_0000, 32'hFFFF_FFFF,
                                  32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                  32'd1, 32'h8000_0000, 1'b0));
      // Small deltas leave bits pending across the next items.
      send_request(record_request(32'h0F0F_0F0F, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd0,
                                  32'd0, 32'd0, 32'd0, 32'd0, 1'b1));
      send_request(word_request(CMD_UNUSED, 32'hFFFF_FFFF));
      send_request(word_request(drbp_pkg::CMD_WORD, 32'hFFFF_0000));
      send_request(word_request(drbp_pkg::CMD_FLUSH, 32'd0));
      send_request(word_request(drbp_pkg::CMD_FLUSH, 32'd0));
      send_request(word_request(CMD_UNUSED, 32'd0));
      send_request(record_request(32'h8000_0000, 32'd100, 32'hFFFF_FF9C, 32'd0,
                                  32'd3_141, 32'd99, 32'hFFFF_FF9D, 32'd0, 32'd0, 1'b1));
      send_request(word_request(drbp_pkg::CMD_FLUSH, 32'd0));
   endtask

   // Random mix of commands with idle bursts on both sides.
   task automatic test_random_mix(input int count);
      request_type r;
      int          taken;
      taken = 0;
      while (taken < count) begin
         r = random_request(random_cmd());
         send_request(r);
         if (r.cmd != CMD_UNUSED) taken++;
      end
   endtask

   // The receiver holds off for a long stretch while records keep coming.
   task automatic test_output_hold_off();
      sender_idling = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
      for (int i = 0; i < 30; i++) begin
         send_request(random_request(drbp_pkg::CMD_RECORD));
      end
      sender_idling = 1'b1;
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_full_rate();
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      test_random_mix(50);
      send_request(word_request(drbp_pkg::CMD_FLUSH, 32'd0));
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = drbp_pkg::CMD_WORD;
      req_word       = '0;
      req_cur_x      = '0;
      req_cur_y      = '0;
      req_cur_z      = '0;
      req_cur_yaw    = '0;
      req_base_x     = '0;
      req_base_y     = '0;
      req_base_z     = '0;
      req_base_yaw   = '0;
      req_base_valid = 1'b0;
      held_bits      = '0;
      held_count     = '0;
      hold_left      = 0;
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_mix(185);
      test_output_hold_off();
      test_full_rate();

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         report_mismatch("bytes never delivered", expected_bytes.size(), 32'd0);
      end

      $display("Sent %0d requests (%0d records) incl. widest and zero deltas and flushes.",
               requests_sent, records_sent);
      $display("Checked %0d stream bytes; request side stalled on %0d cycles.",
               bytes_checked, input_stall_cycles);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
